### hdl/max_empty_rectangle_area_top_assert.svh
// ----------------------------------------------------------------------------
// max_empty_rectangle_area_top_assert.svh
// Assertion macros for the maximal empty rectangle block.
// ----------------------------------------------------------------------------
`ifndef MAX_EMPTY_RECTANGLE_AREA_TOP_ASSERT_SVH
`define MAX_EMPTY_RECTANGLE_AREA_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, reset disables the check
`define MERA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, reset disables the check
`define MERA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MERA_ASSERT_NOW(lbl, ante, cons, msg)
`define MERA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/mera_pkg.sv
// ----------------------------------------------------------------------------
// mera_pkg
// Shared constants, command and status types of the rectangle area block.
// ----------------------------------------------------------------------------
`default_nettype none

package mera_pkg;

  localparam int unsigned MaxColumns = 64;
  localparam int unsigned ColW       = 6;
  localparam int unsigned CountW     = 7;
  localparam int unsigned HeightW    = 11;
  localparam int unsigned AreaW      = 17;
  localparam int unsigned HlW        = HeightW + ColW;

  localparam logic [HeightW-1:0] HeightCap = 11'd2047;
  localparam logic [CountW-1:0]  CountReset = 7'd64;

  // Register index codes (paddr bit 2)
  localparam logic RegColumnCount = 1'b0;

  // Column store read address select
  typedef enum logic [1:0] {
    RD_COL,
    RD_K,
    RD_K_PREV
  } mera_rdsel_e;

  // Controller to datapath
  typedef struct packed {
    mera_rdsel_e rd_sel;
    logic        load;
    logic        pass_step;
    logic        emit_mul;
    logic        emit_push;
  } mera_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic row_end;
    logic pass_done;
    logic emit_last;
    logic out_free;
  } mera_stat_t;

endpackage

`default_nettype wire

### hdl/mera_ram.sv
// ----------------------------------------------------------------------------
// mera_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mera_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/mera_ctrl.sv
// ----------------------------------------------------------------------------
// mera_ctrl
// Sequencer: cell load, right-to-left bound pass, per-column area emission.
// ----------------------------------------------------------------------------
`default_nettype none

module mera_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_clear_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire mera_pkg::mera_stat_t stat_i,
  output mera_pkg::mera_cmd_t       cmd_o
);

  import mera_pkg::*;

  localparam logic [2:0] S_FETCH      = 3'd0;
  localparam logic [2:0] S_LOAD       = 3'd1;
  localparam logic [2:0] S_PASS_PRIME = 3'd2;
  localparam logic [2:0] S_PASS       = 3'd3;
  localparam logic [2:0] S_EMIT_RD    = 3'd4;
  localparam logic [2:0] S_EMIT_MUL   = 3'd5;
  localparam logic [2:0] S_EMIT_PUSH  = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    in_stall_o       = 1'b1;
    cmd_o.rd_sel     = RD_K;
    cmd_o.load       = 1'b0;
    cmd_o.pass_step  = 1'b0;
    cmd_o.emit_mul   = 1'b0;
    cmd_o.emit_push  = 1'b0;
    unique case (state_q)
      S_FETCH: begin
        cmd_o.rd_sel = RD_COL;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.rd_sel = RD_COL;
        in_stall_o   = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.row_end ? S_PASS_PRIME : S_FETCH;
        end
      end
      S_PASS_PRIME: begin
        cmd_o.rd_sel = RD_K;
        state_d      = S_PASS;
      end
      S_PASS: begin
        // write bound k, fetch bound k-1
        cmd_o.rd_sel    = RD_K_PREV;
        cmd_o.pass_step = 1'b1;
        if (stat_i.pass_done) begin
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd_o.rd_sel = RD_K;
        state_d      = S_EMIT_MUL;
      end
      S_EMIT_MUL: begin
        cmd_o.emit_mul = 1'b1;
        state_d        = S_EMIT_PUSH;
      end
      S_EMIT_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.emit_push = 1'b1;
          state_d         = stat_i.emit_last ? S_FETCH : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_FETCH;
      end
    endcase
    // register write restarts the row
    if (cfg_clear_i) begin
      state_d = S_FETCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FETCH;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/mera_dpath.sv
// ----------------------------------------------------------------------------
// mera_dpath
// Column stores, bound update logic, area multiply and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mera_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_clear_i,
  input  wire logic [5:0]           last_col_i,
  input  wire mera_pkg::mera_cmd_t  cmd_i,
  output mera_pkg::mera_stat_t      stat_o,
  input  wire logic                 cell_blocked_i,
  input  wire logic                 last_cell_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [5:0]                column_index_o,
  output logic [16:0]               cell_area_o,
  output logic [16:0]               best_area_o,
  output logic                      row_done_o,
  output logic                      matrix_done_o
);

  import mera_pkg::*;

  // Control state
  logic [ColW-1:0]       col_q, col_d;
  logic [CountW-1:0]     rll_q, rll_d;
  logic [ColW-1:0]       end_q, end_d;
  logic                  last_q, last_d;
  logic [ColW-1:0]       k_q, k_d;
  logic [ColW-1:0]       limit_q, limit_d;
  logic                  limit_ok_q, limit_ok_d;
  logic [AreaW-1:0]      best_q, best_d;
  logic [MaxColumns-1:0] hl_vld_q, hl_vld_d;
  logic [MaxColumns-1:0] r_vld_q, r_vld_d;
  logic                  hl_vld_rd_q, r_vld_rd_q;
  logic                  out_vld_q, out_vld_d;

  // Payload
  logic [AreaW-1:0]      area_q, area_d;
  logic [ColW-1:0]       oidx_q, oidx_d;
  logic [AreaW-1:0]      oarea_q, oarea_d;
  logic [AreaW-1:0]      obest_q, obest_d;
  logic                  orow_q, orow_d;
  logic                  omat_q, omat_d;

  // Store access
  logic [ColW-1:0]       rd_addr;
  logic [HlW-1:0]        hl_rdata;
  logic [ColW-1:0]       r_rdata;
  logic                  blk_rdata;
  logic [HeightW-1:0]    h_cur, h_new;
  logic [ColW-1:0]       l_cur, l_new;
  logic [ColW-1:0]       r_cur, r_new;
  logic [CountW-1:0]     width;
  logic [HeightW+CountW-1:0] area_full;
  logic [AreaW-1:0]      best_new;

  // Read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RD_COL:    rd_addr = col_q;
      RD_K:      rd_addr = k_q;
      RD_K_PREV: rd_addr = k_q - 1'b1;
      default:   rd_addr = k_q;
    endcase
  end

  mera_ram #(.WIDTH(HlW), .DEPTH(MaxColumns)) u_hl_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (col_q),
    .wdata_i ({h_new, l_new}),
    .raddr_i (rd_addr),
    .rdata_o (hl_rdata)
  );

  mera_ram #(.WIDTH(ColW), .DEPTH(MaxColumns)) u_r_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pass_step),
    .waddr_i (k_q),
    .wdata_i (r_new),
    .raddr_i (rd_addr),
    .rdata_o (r_rdata)
  );

  mera_ram #(.WIDTH(1), .DEPTH(MaxColumns)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (col_q),
    .wdata_i (cell_blocked_i),
    .raddr_i (rd_addr),
    .rdata_o (blk_rdata)
  );

  // Entries not yet written read as their reset values
  assign h_cur = hl_vld_rd_q ? hl_rdata[HlW-1:ColW] : '0;
  assign l_cur = hl_vld_rd_q ? hl_rdata[ColW-1:0] : '0;
  assign r_cur = r_vld_rd_q ? r_rdata : last_col_i;

  // Height and left bound update for the arriving cell
  always_comb begin
    if (cell_blocked_i) begin
      h_new = '0;
      l_new = '0;
    end else begin
      h_new = (h_cur < HeightCap) ? h_cur + 11'd1 : h_cur;
      l_new = ({1'b0, l_cur} < rll_q) ? rll_q[ColW-1:0] : l_cur;
    end
  end

  // Right bound update in the right-to-left pass
  always_comb begin
    if (blk_rdata) begin
      r_new = end_q;
    end else if (limit_ok_q && (r_cur > limit_q)) begin
      r_new = limit_q;
    end else begin
      r_new = r_cur;
    end
  end

  // Area of the fetched column
  assign width     = (r_cur >= l_cur) ? ({1'b0, r_cur} - {1'b0, l_cur} + 7'd1) : 7'd0;
  assign area_full = {{CountW{1'b0}}, h_cur} * {{HeightW{1'b0}}, width};
  assign best_new  = (area_q > best_q) ? area_q : best_q;

  // Next state
  always_comb begin
    col_d      = col_q;
    rll_d      = rll_q;
    end_d      = end_q;
    last_d     = last_q;
    k_d        = k_q;
    limit_d    = limit_q;
    limit_ok_d = limit_ok_q;
    best_d     = best_q;
    hl_vld_d   = hl_vld_q;
    r_vld_d    = r_vld_q;
    area_d     = area_q;
    oidx_d     = oidx_q;
    oarea_d    = oarea_q;
    obest_d    = obest_q;
    orow_d     = orow_q;
    omat_d     = omat_q;
    out_vld_d  = out_vld_q && out_stall_i;

    if (cfg_clear_i) begin
      col_d    = '0;
      rll_d    = '0;
      best_d   = '0;
      hl_vld_d = '0;
      r_vld_d  = '0;
    end else begin
      if (cmd_i.load) begin
        hl_vld_d[col_q] = 1'b1;
        if (cell_blocked_i) begin
          rll_d = {1'b0, col_q} + 7'd1;
        end
        if (stat_o.row_end) begin
          end_d      = col_q;
          k_d        = col_q;
          limit_d    = col_q;
          limit_ok_d = 1'b1;
          last_d     = last_cell_i;
        end else begin
          col_d = col_q + 1'b1;
        end
      end

      if (cmd_i.pass_step) begin
        r_vld_d[k_q] = 1'b1;
        if (blk_rdata) begin
          if (k_q == '0) begin
            limit_ok_d = 1'b0;
          end else begin
            limit_d = k_q - 1'b1;
          end
        end
        if (k_q != '0) begin
          k_d = k_q - 1'b1;
        end
      end

      if (cmd_i.emit_mul) begin
        area_d = area_full[AreaW-1:0];
      end

      if (cmd_i.emit_push) begin
        out_vld_d = 1'b1;
        oidx_d    = k_q;
        oarea_d   = area_q;
        obest_d   = best_new;
        orow_d    = stat_o.emit_last;
        omat_d    = stat_o.emit_last && last_q;
        best_d    = best_new;
        if (stat_o.emit_last) begin
          col_d = '0;
          rll_d = '0;
          // matrix ends: back to reset state
          if (last_q) begin
            best_d   = '0;
            hl_vld_d = '0;
            r_vld_d  = '0;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      rll_q       <= '0;
      end_q       <= '0;
      last_q      <= 1'b0;
      k_q         <= '0;
      limit_q     <= '0;
      limit_ok_q  <= 1'b0;
      best_q      <= '0;
      hl_vld_q    <= '0;
      r_vld_q     <= '0;
      hl_vld_rd_q <= 1'b0;
      r_vld_rd_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      col_q       <= col_d;
      rll_q       <= rll_d;
      end_q       <= end_d;
      last_q      <= last_d;
      k_q         <= k_d;
      limit_q     <= limit_d;
      limit_ok_q  <= limit_ok_d;
      best_q      <= best_d;
      hl_vld_q    <= hl_vld_d;
      r_vld_q     <= r_vld_d;
      hl_vld_rd_q <= hl_vld_q[rd_addr];
      r_vld_rd_q  <= r_vld_q[rd_addr];
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    area_q  <= area_d;
    oidx_q  <= oidx_d;
    oarea_q <= oarea_d;
    obest_q <= obest_d;
    orow_q  <= orow_d;
    omat_q  <= omat_d;
  end

  // Status
  assign stat_o.row_end   = (col_q == last_col_i) || last_cell_i;
  assign stat_o.pass_done = (k_q == '0);
  assign stat_o.emit_last = (k_q == end_q);
  assign stat_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o    = out_vld_q;
  assign column_index_o = oidx_q;
  assign cell_area_o    = oarea_q;
  assign best_area_o    = obest_q;
  assign row_done_o     = orow_q;
  assign matrix_done_o  = omat_q;

endmodule

`default_nettype wire

### hdl/max_empty_rectangle_area_top.sv
// ----------------------------------------------------------------------------
// max_empty_rectangle_area_top
// Maximal empty rectangle, column histogram scheme, over a streamed grid.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  input    in         in_valid_i/in_stall_o  cell_blocked_i, last_cell_i
//  output   out        out_valid_o/out_stall_i column_index_o, cell_area_o,
//                                             best_area_o, row_done_o, matrix_done_o
//  config   APB        psel/penable/pready    paddr, pwdata, prdata
//
//  A cell goes through a column store read, then an update and write.
//  At a row end a right bound pass runs right to left over the row, then
//  each result takes a store read, a multiply and a push that waits on out_stall_i.
//  Reset is asynchronous; stores need no clearing pass (valid bits per column).
//  A new row is taken while the final result of the previous row waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_empty_rectangle_area_top_assert.svh"

module max_empty_rectangle_area_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // cells
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cell_blocked_i,
  input  wire logic        last_cell_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       column_index_o,
  output logic [16:0]      cell_area_o,
  output logic [16:0]      best_area_o,
  output logic             row_done_o,
  output logic             matrix_done_o
);

  import mera_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] cols_eff;
  logic [ColW-1:0]   last_col;
  logic              cfg_wr;
  mera_cmd_t         cmd;
  mera_stat_t        stat;

  // Register write decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == RegColumnCount);
  assign count_d = cfg_wr ? pwdata[CountW-1:0] : count_q;
  assign prdata  = (paddr[2] == RegColumnCount) ? {{(32 - CountW){1'b0}}, count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else begin
      count_q <= count_d;
    end
  end

  // Effective column count, clamped to 1..MaxColumns
  always_comb begin
    if (count_q == '0) begin
      cols_eff = CountW'(1);
    end else if (count_q > CountW'(MaxColumns)) begin
      cols_eff = CountW'(MaxColumns);
    end else begin
      cols_eff = count_q;
    end
  end
  assign last_col = ColW'(cols_eff - CountW'(1));

  mera_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clear_i (cfg_wr),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mera_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_clear_i    (cfg_wr),
    .last_col_i     (last_col),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cell_blocked_i (cell_blocked_i),
    .last_cell_i    (last_cell_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_index_o (column_index_o),
    .cell_area_o    (cell_area_o),
    .best_area_o    (best_area_o),
    .row_done_o     (row_done_o),
    .matrix_done_o  (matrix_done_o)
  );

  // Assertions
  `MERA_ASSERT_NEXT(a_stall_after_cell, in_valid_i && !in_stall_o, in_stall_o, "cell taken twice")
  `MERA_ASSERT_NOW(a_index_in_row, out_valid_o, column_index_o <= last_col, "index past row")
  `MERA_ASSERT_NOW(a_emit_blocks_in, out_valid_o && !row_done_o, in_stall_o, "cell taken in emit")

endmodule

`default_nettype wire

### bench/tb_max_empty_rectangle_area_top.sv
// ----------------------------------------------------------------------------
// tb_max_empty_rectangle_area_top
// Self-checking bench for the streamed maximal empty rectangle block.
// Grids are pushed cell by cell under several column counts. A local
// histogram model keeps heights and left/right bounds per column. It
// predicts each row's area results, which the monitor checks field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_max_empty_rectangle_area_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mera_pkg::*;

  localparam int RandomCells  = 370;
  localparam int SettleCycles = 2 * MaxColumns + 16;
  localparam int CycleLimit   = 2_000_000;
  localparam int MaxPrinted   = 30;

  // one cell waiting to be driven, with the idle gap in front of it
  typedef struct {
    bit blocked;
    bit last;
    int gap;
  } pending_cell_t;

  // one predicted area transaction
  typedef struct packed {
    logic [5:0]  col;
    logic [16:0] area;
    logic [16:0] best;
    logic        row_end;
    logic        grid_end;
  } area_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cell_blocked_i = 1'b0;
  logic        last_cell_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  column_index_o;
  logic [16:0] cell_area_o;
  logic [16:0] best_area_o;
  logic        row_done_o;
  logic        matrix_done_o;

  max_empty_rectangle_area_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cell_blocked_i (cell_blocked_i),
    .last_cell_i    (last_cell_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_index_o (column_index_o),
    .cell_area_o    (cell_area_o),
    .best_area_o    (best_area_o),
    .row_done_o     (row_done_o),
    .matrix_done_o  (matrix_done_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bench bookkeeping
  pending_cell_t cell_queue[$];
  area_result_t  expected_areas[$];
  int            error_count = 0;
  int            checked_count = 0;
  int            cells_sent = 0;
  int            grids_closed = 0;
  int            setting_count = 0;
  int            cycle_count = 0;

  // histogram model state
  logic [6:0]  col_count_reg;
  logic [10:0] col_height [MaxColumns];
  logic [5:0]  col_left   [MaxColumns];
  logic [5:0]  col_right  [MaxColumns];
  bit          row_blk    [MaxColumns];
  logic [6:0]  left_limit;
  logic [5:0]  col_ptr;
  logic [16:0] best_seen;

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MaxPrinted) $display("[%0t] %s", $realtime, msg);
  endtask

  // 0 behaves as one column, anything past the store depth as the full depth
  function automatic int unsigned eff_cols(logic [6:0] c);
    if (c == 0) return 1;
    if (c > MaxColumns) return MaxColumns;
    return c;
  endfunction

  function void clear_grid();
    int unsigned lastc;
    lastc = eff_cols(col_count_reg) - 1;
    for (int k = 0; k < MaxColumns; k++) begin
      col_height[k] = '0;
      col_left[k]   = '0;
      col_right[k]  = 6'(lastc);
      row_blk[k]    = 1'b0;
    end
    left_limit = '0;
    col_ptr    = '0;
    best_seen  = '0;
  endfunction

  // Take one cell; at a row end run the right-bound pass and queue the areas
  function void advance_histogram(bit blocked, bit last);
    int unsigned n, j, stop, lim, h, l, r, w;
    logic [16:0] area;
    bit lim_ok;
    area_result_t res;
    n = eff_cols(col_count_reg);
    j = col_ptr;
    if (j >= n) j = n - 1;
    row_blk[j] = blocked;
    if (!blocked) begin
      if (col_height[j] < HeightCap) col_height[j] = col_height[j] + 1'b1;
      if (col_left[j] < left_limit) col_left[j] = left_limit[5:0];
    end else begin
      col_height[j] = '0;
      col_left[j]   = '0;
      left_limit    = 7'(j + 1);
    end
    if (j != n - 1 && !last) begin
      col_ptr = 6'(j + 1);
      return;
    end
    // right-to-left pass: free cells are clipped by the nearest block on the right
    stop   = j;
    lim    = stop;
    lim_ok = 1'b1;
    for (int k = stop; k >= 0; k--) begin
      if (!row_blk[k]) begin
        if (lim_ok && col_right[k] > lim) col_right[k] = 6'(lim);
      end else begin
        col_right[k] = 6'(stop);
        if (k > 0) lim = k - 1;
        else lim_ok = 1'b0;
      end
    end
    for (int k = 0; k <= stop; k++) begin
      h = col_height[k];
      l = col_left[k];
      r = col_right[k];
      w = (r >= l) ? (r - l + 1) : 0;
      area = 17'(h * w);
      if (area > best_seen) best_seen = area;
      res.col      = 6'(k);
      res.area     = area;
      res.best     = best_seen;
      res.row_end  = (k == stop);
      res.grid_end = (k == stop) && last;
      expected_areas.push_back(res);
    end
    left_limit = '0;
    col_ptr    = '0;
    if (last) clear_grid();
  endfunction

  // Cell driver: a gap drawn per cell, then valid held until taken
  int  gap_left = 0;
  bit  gap_loaded = 1'b0;
  bit  next_valid;
  pending_cell_t head_cell;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_histogram(cell_blocked_i, last_cell_i);
        cells_sent++;
      end
      if ((in_valid_i && !in_stall_o) || !in_valid_i) begin
        next_valid = 1'b0;
        if (cell_queue.size() != 0) begin
          if (!gap_loaded) begin
            gap_left   = cell_queue[0].gap;
            gap_loaded = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            head_cell      = cell_queue.pop_front();
            gap_loaded     = 1'b0;
            cell_blocked_i <= head_cell.blocked;
            last_cell_i    <= head_cell.last;
            next_valid     = 1'b1;
          end
        end
        in_valid_i <= next_valid;
      end
    end
  end

  // Result monitor: checks each transaction, stalls a drawn number of cycles
  int           stall_left = 0;
  bit           out_no_stall = 1'b0;
  area_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_count++;
      if (matrix_done_o) grids_closed++;
      if (expected_areas.size() == 0) begin
        report_error($sformatf("unexpected result: column %0d area %0d",
                               column_index_o, cell_area_o));
      end else begin
        want = expected_areas.pop_front();
        if (column_index_o !== want.col)
          report_error($sformatf("result %0d column_index %0d, want %0d",
                                 checked_count, column_index_o, want.col));
        if (cell_area_o !== want.area)
          report_error($sformatf("result %0d cell_area %0d, want %0d (column %0d)",
                                 checked_count, cell_area_o, want.area, want.col));
        if (best_area_o !== want.best)
          report_error($sformatf("result %0d best_area %0d, want %0d (column %0d)",
                                 checked_count, best_area_o, want.best, want.col));
        if (row_done_o !== want.row_end)
          report_error($sformatf("result %0d row_done %0b, want %0b (column %0d)",
                                 checked_count, row_done_o, want.row_end, want.col));
        if (matrix_done_o !== want.grid_end)
          report_error($sformatf("result %0d matrix_done %0b, want %0b (column %0d)",
                                 checked_count, matrix_done_o, want.grid_end, want.col));
      end
      // occasionally switch between stalling and full-rate stretches
      if ($urandom_range(0, 49) == 0) out_no_stall = !out_no_stall;
      stall_left = out_no_stall ? 0 : $urandom_range(0, 19);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycle_count, expected_areas.size());
      $display("tb_max_empty_rectangle_area_top: errors");
      $finish;
    end
  end

  // APB write of the column count, read back, then the model follows
  task automatic program_columns(logic [6:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegColumnCount, 2'b00};
    pwdata  <= {25'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[6:0] !== value)
      report_error($sformatf("column_count read back %0d, wrote %0d", prdata[6:0], value));
    psel    <= 1'b0;
    penable <= 1'b0;
    col_count_reg = value;
    clear_grid();
    setting_count++;
  endtask

  task automatic queue_cell(bit blocked, bit last, bit no_gaps);
    pending_cell_t c;
    c.blocked = blocked;
    c.last    = last;
    c.gap     = no_gaps ? 0 : $urandom_range(0, 19);
    cell_queue.push_back(c);
  endtask

  // One grid of random content; may close early inside its final row
  task automatic queue_grid(int n, int rows, int blocked_pct, bit end_early,
                            bit no_gaps, inout int queued);
    int final_len;
    final_len = end_early ? $urandom_range(1, n) : n;
    for (int rw = 0; rw < rows; rw++) begin
      for (int c = 0; c < ((rw == rows - 1) ? final_len : n); c++) begin
        queue_cell($urandom_range(0, 99) < blocked_pct,
                   (rw == rows - 1) && (c == final_len - 1), no_gaps);
        queued++;
      end
    end
  endtask

  // Wait until every cell is taken and every area has come back
  task automatic wait_idle();
    while (cell_queue.size() != 0 || in_valid_i || expected_areas.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  int queued = 0;
  int n_cols, rows, rows_max, grids, pct;
  bit burst;
  logic [6:0] setting;
  int density_pick[6] = '{0, 10, 30, 50, 80, 100};
  logic [6:0] early_settings[5] = '{7'd1, 7'd127, 7'd64, 7'd2, 7'd63};

  initial begin
    col_count_reg = CountReset;
    clear_grid();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset column count, grid closed at column 3
    queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b1, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b1, 1'b0);
    wait_idle();

    // directed: 4 columns, blocks at the edges and inside, early close
    program_columns(7'd4);
    queue_cell(1'b0, 1'b0, 1'b0); queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b0, 1'b0); queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b1, 1'b0, 1'b0); queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b0, 1'b0); queue_cell(1'b1, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b0, 1'b0); queue_cell(1'b1, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b0, 1'b0); queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b0, 1'b0); queue_cell(1'b0, 1'b1, 1'b0);
    // single blocked cell forms a whole grid
    queue_cell(1'b1, 1'b1, 1'b0);
    wait_idle();

    // directed: a single column
    program_columns(7'd1);
    queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b0, 1'b0);
    queue_cell(1'b1, 1'b0, 1'b0);
    queue_cell(1'b0, 1'b1, 1'b0);
    wait_idle();

    // random grids under a series of column counts
    for (int ph = 0; queued < RandomCells; ph++) begin
      if (ph < 5) setting = early_settings[ph];
      else if ($urandom_range(0, 7) == 0) setting = 7'($urandom_range(65, 127));
      else setting = 7'($urandom_range(1, 64));
      program_columns(setting);
      n_cols   = eff_cols(setting);
      rows_max = 64 / n_cols;
      if (rows_max > 24) rows_max = 24;
      if (rows_max < 1) rows_max = 1;
      grids = $urandom_range(1, 2);
      for (int g = 0; g < grids; g++) begin
        rows  = $urandom_range(1, rows_max);
        pct   = density_pick[$urandom_range(0, 5)];
        burst = ($urandom_range(0, 3) == 0);
        queue_grid(n_cols, rows, pct, $urandom_range(0, 3) == 0, burst, queued);
      end
      wait_idle();
    end

    if (expected_areas.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_areas.size()));
    $display("%0d cells over %0d column settings; %0d area results checked, %0d grids closed",
             cells_sent, setting_count, checked_count, grids_closed);
    if (error_count == 0) begin
      $display("tb_max_empty_rectangle_area_top: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_max_empty_rectangle_area_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
